[src/rational_cubic_resampler_assert.svh]
// Assertion macros shared by the resampler RTL.
// Each macro expects clk_i and rst_ni to be in scope at the point of use.
`ifndef RATIONAL_CUBIC_RESAMPLER_ASSERT_SVH
`define RATIONAL_CUBIC_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define RCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rcr_pkg.sv]
// Package for the rational cubic resampler: ratio, widths, queue entry type,
// and the constant weight and emit tables. No dependencies.
package rcr_pkg;

  localparam int UP_FACTOR        = 3;
  localparam int DOWN_FACTOR      = 5;
  localparam int SAMPLE_BITS      = 16;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int WGT_BITS  = WEIGHT_FRAC_BITS + 2;
  localparam int PROD_BITS = SAMPLE_BITS + WGT_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int PH_W      = (UP_FACTOR > 1) ? $clog2(UP_FACTOR) : 1;
  localparam int CNT_W     = (DOWN_FACTOR > 1) ? $clog2(DOWN_FACTOR) : 1;
  localparam int OUT_PH_W  = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam longint WDEN2 = 12 * UP_FACTOR * UP_FACTOR * UP_FACTOR;
  localparam longint WDEN  = 6 * UP_FACTOR * UP_FACTOR * UP_FACTOR;

  typedef logic [3:0][SAMPLE_BITS-1:0] win_t;  // index 0 is oldest

  typedef struct packed {
    win_t                 win;
    logic [UP_FACTOR-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [UP_FACTOR-1:0][3:0][WGT_BITS-1:0] wtab_t;
  typedef logic [DOWN_FACTOR-1:0][UP_FACTOR-1:0]   mtab_t;

  function automatic logic [WGT_BITS-1:0] weight_f(int k, int ph);
    longint a;
    longint p;
    longint n;
    longint m;
    longint q;
    longint r;
    p = UP_FACTOR;
    a = (ph * DOWN_FACTOR) % UP_FACTOR;
    case (k)
      0:       n = -a * (a - p) * (a - 2 * p);
      1:       n = 3 * (a + p) * (a - p) * (a - 2 * p);
      2:       n = -3 * (a + p) * a * (a - 2 * p);
      default: n = (a + p) * a * (a - p);
    endcase
    n = n * (longint'(1) <<< WEIGHT_FRAC_BITS);
    m = (n < 0) ? -n : n;
    q = (2 * m + WDEN) / WDEN2;
    r = (n < 0) ? -q : q;
    return r[WGT_BITS-1:0];
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t t;
    for (int ph = 0; ph < UP_FACTOR; ph++) begin
      for (int k = 0; k < 4; k++) begin
        t[ph][k] = weight_f(k, ph);
      end
    end
    return t;
  endfunction

  // Bit ph of row b is set when output phase ph takes its newest sample at
  // block position b.
  function automatic mtab_t build_mtab();
    mtab_t t;
    for (int b = 0; b < DOWN_FACTOR; b++) begin
      for (int ph = 0; ph < UP_FACTOR; ph++) begin
        t[b][ph] = (((ph * DOWN_FACTOR) / UP_FACTOR) == b);
      end
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();
  localparam mtab_t MTAB = build_mtab();

endpackage

[src/rcr_front.sv]
// Front end: takes input words, keeps the four-sample window and block count,
// and queues a window with the set of phases it completes. Uses rcr_pkg.
module rcr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rcr_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  rcr_pkg::q_status_t                  q_status_i,
  output logic                                push_o,
  output rcr_pkg::entry_t                     entry_o
);
  import rcr_pkg::*;

  win_t             win_q, win_d;
  logic [1:0]       fill_q, fill_d;
  logic [CNT_W-1:0] bcnt_q, bcnt_d;
  logic             accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    bcnt_d = bcnt_q;
    if (accept) begin
      win_d = {sample_in_i, win_q[3], win_q[2], win_q[1]};
      if (fill_q != 2'd3) begin
        fill_d = fill_q + 2'd1;
      end else if (bcnt_q == CNT_W'(DOWN_FACTOR - 1)) begin
        bcnt_d = '0;
      end else begin
        bcnt_d = bcnt_q + CNT_W'(1);
      end
    end
  end

  assign entry_o.win  = win_d;
  assign entry_o.mask = MTAB[bcnt_q];
  assign push_o       = accept && (fill_q == 2'd3) && (MTAB[bcnt_q] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      bcnt_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      bcnt_q <= bcnt_d;
    end
  end

endmodule

[src/rcr_queue.sv]
// Short queue of windows between front and back ends.
// Uses rcr_pkg and the assertion macro header.
`include "rational_cubic_resampler_assert.svh"
module rcr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rcr_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output rcr_pkg::entry_t    entry_o,
  output rcr_pkg::q_status_t status_o
);
  import rcr_pkg::*;

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign entry_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `RCR_ASSERT_NOW(a_no_push_full, push_i, !status_o.full, "push into full queue")
  `RCR_ASSERT_NOW(a_no_pop_empty, pop_i, !status_o.empty, "pop from empty queue")
  `RCR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

[src/rcr_back.sv]
// Back end: issues one phase per cycle from the current window unless the
// output stalls, multiplies by the weight row, then sums, rounds and saturates
// into the output register. Uses rcr_pkg and the assertion macro header.
`include "rational_cubic_resampler_assert.svh"
module rcr_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rcr_pkg::entry_t                       entry_i,
  input  rcr_pkg::q_status_t                    q_status_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rcr_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [rcr_pkg::OUT_PH_W-1:0]          out_phase_o,
  output logic                                  last_of_run_o
);
  import rcr_pkg::*;

  localparam logic signed [ACC_BITS-1:0] SMAX =
    ACC_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SMIN =
    ACC_BITS'(-(longint'(1) <<< (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_BITS-1:0] RND =
    ACC_BITS'(longint'(1) <<< (WEIGHT_FRAC_BITS - 1));

  win_t                         cur_win_q;
  logic [UP_FACTOR-1:0]         cur_mask_q;
  logic [UP_FACTOR-1:0]         pick_oh;
  logic [UP_FACTOR-1:0]         rem;
  logic [PH_W-1:0]              pick_idx;
  logic                         adv, issue, load;

  logic                         s1_vld_q;
  logic signed [PROD_BITS-1:0]  s1_prod_q [4];
  logic [PH_W-1:0]              s1_ph_q;
  logic                         s1_last_q;

  logic                         out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;
  logic [PH_W-1:0]              out_ph_q;
  logic                         out_last_q;

  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS-1:0]   shf;
  logic signed [SAMPLE_BITS-1:0] sat;

  // lowest pending phase first
  always_comb begin
    pick_idx = '0;
    pick_oh  = '0;
    for (int i = UP_FACTOR - 1; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        pick_idx = PH_W'(i);
        pick_oh  = UP_FACTOR'(1) << i;
      end
    end
  end

  assign rem   = cur_mask_q & ~pick_oh;
  assign adv   = !out_vld_q || !out_stall_i;
  assign issue = adv && (cur_mask_q != '0);
  assign load  = ((cur_mask_q == '0) || (issue && (rem == '0))) && !q_status_i.empty;
  assign pop_o = load;

  always_comb begin
    acc = RND;
    for (int k = 0; k < 4; k++) begin
      acc = acc + ACC_BITS'(s1_prod_q[k]);
    end
    shf = acc >>> WEIGHT_FRAC_BITS;
    if (shf > SMAX) begin
      sat = SAMPLE_BITS'(SMAX);
    end else if (shf < SMIN) begin
      sat = SAMPLE_BITS'(SMIN);
    end else begin
      sat = SAMPLE_BITS'(shf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mask_q <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load) begin
        cur_mask_q <= entry_i.mask;
      end else if (issue) begin
        cur_mask_q <= rem;
      end
      if (adv) begin
        s1_vld_q  <= issue;
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_win_q <= entry_i.win;
    end
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s1_prod_q[k] <= $signed(WTAB[pick_idx][k]) * $signed(cur_win_q[k]);
      end
      s1_ph_q    <= pick_idx;
      s1_last_q  <= (rem == '0);
      out_smp_q  <= sat;
      out_ph_q   <= s1_ph_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign sample_out_o  = out_smp_q;
  assign out_phase_o   = OUT_PH_W'(out_ph_q);
  assign last_of_run_o = out_last_q;

  `RCR_ASSERT_NOW(a_pick_onehot, cur_mask_q != '0, $onehot(pick_oh), "bad phase pick")
  `RCR_ASSERT_NEXT(a_issue_s1, issue, s1_vld_q, "issued phase lost")
  `RCR_ASSERT_NOW(a_load_free, load && !issue, cur_mask_q == '0, "window overwritten")

endmodule

[src/rational_cubic_resampler.sv]
// Top level of the rational cubic resampler: front end, window queue, back end.
// Uses rcr_pkg, rcr_front, rcr_queue and rcr_back.
//
//   channel  dir  handshake              words
//   input    in   in_valid_i/in_stall_o  sample_in_i
//   output   out  out_valid_o/out_stall_i sample_out_o, out_phase_o, last_of_run_o
//
// Input: one word per cycle while the two-entry window queue has room.
// Output: one word per cycle while out_stall_i is low, from the back end's multiply
// and sum stages; an input word completing n phases gives n output words in turn.
// An accepted word passes the queue memory, window, product and output registers.
// Reset clears window, counters, queue and pipeline valids; no clearing pass.
// out_stall_i freezes the back end; the queue absorbs two windows, then in_stall_o rises.
module rational_cubic_resampler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rcr_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rcr_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [rcr_pkg::OUT_PH_W-1:0]          out_phase_o,
  output logic                                  last_of_run_o
);
  import rcr_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    head_entry;
  logic      push;
  logic      pop;

  rcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  rcr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  rcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .out_phase_o   (out_phase_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for rational_cubic_resampler: directed and random sample
// words are checked against a cubic interpolation predictor. Depends on rcr_pkg and the RTL.
module testbench;
  import rcr_pkg::*;

  localparam int NUM_RANDOM  = 405;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t             value;
    logic [OUT_PH_W-1:0] phase;
    logic                last;
  } interp_word_t;

  class resample_checker;
    sample_t      window[4];
    int           fill_cnt;
    int           blk_pos;
    int           mismatch_count;
    interp_word_t pending_outputs[$];

    function new();
      for (int k = 0; k < 4; k++) window[k] = '0;
      fill_cnt = 0;
      blk_pos = 0;
      mismatch_count = 0;
    endfunction

    // Lagrange tap weight, rounded half away from zero to WEIGHT_FRAC_BITS
    function longint tap_weight(int k, int ph);
      longint a;
      longint p;
      longint num;
      longint den;
      longint mag;
      p = UP_FACTOR;
      a = (ph * DOWN_FACTOR) % UP_FACTOR;
      den = 6 * p * p * p;
      case (k)
        0:       num = -a * (a - p) * (a - 2 * p);
        1:       num = 3 * (a + p) * (a - p) * (a - 2 * p);
        2:       num = -3 * (a + p) * a * (a - 2 * p);
        default: num = (a + p) * a * (a - p);
      endcase
      num = num * (longint'(1) << WEIGHT_FRAC_BITS);
      mag = (num < 0) ? -num : num;
      mag = (2 * mag + den) / (2 * den);
      return (num < 0) ? -mag : mag;
    endfunction

    function sample_t interpolate_phase(int ph);
      longint acc;
      longint lim_hi;
      longint lim_lo;
      lim_hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      lim_lo = -(longint'(1) << (SAMPLE_BITS - 1));
      acc = 0;
      for (int k = 0; k < 4; k++) acc += tap_weight(k, ph) * longint'(window[k]);
      acc += longint'(1) << (WEIGHT_FRAC_BITS - 1);
      acc = acc >>> WEIGHT_FRAC_BITS;
      if (acc > lim_hi) acc = lim_hi;
      if (acc < lim_lo) acc = lim_lo;
      return sample_t'(acc);
    endfunction

    function void take_sample(sample_t s);
      interp_word_t w;
      int n;
      for (int k = 0; k < 3; k++) window[k] = window[k+1];
      window[3] = s;
      if (fill_cnt < 3) begin
        fill_cnt++;
        return;
      end
      n = 0;
      for (int ph = 0; ph < UP_FACTOR; ph++) begin
        if ((ph * DOWN_FACTOR) / UP_FACTOR == blk_pos) begin
          w.value = interpolate_phase(ph);
          w.phase = OUT_PH_W'(ph);
          w.last  = 1'b0;
          pending_outputs.push_back(w);
          n++;
        end
      end
      if (n > 0) pending_outputs[pending_outputs.size()-1].last = 1'b1;
      blk_pos++;
      if (blk_pos >= DOWN_FACTOR) blk_pos = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_output(sample_t value, logic [OUT_PH_W-1:0] phase, logic last);
      interp_word_t w;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%0d phase=%0d", value, phase));
        return;
      end
      w = pending_outputs.pop_front();
      if (value !== w.value)
        report_mismatch($sformatf("sample_out %0d, want %0d", value, w.value));
      if (phase !== w.phase)
        report_mismatch($sformatf("out_phase %0d, want %0d", phase, w.phase));
      if (last !== w.last)
        report_mismatch($sformatf("last_of_run %0b, want %0b", last, w.last));
    endtask
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  sample_t sample_in_i;
  logic    out_valid_o;
  logic    out_stall_i;
  sample_t sample_out_o;
  logic [OUT_PH_W-1:0] out_phase_o;
  logic    last_of_run_o;

  resample_checker checker_h;
  int  cyc_cnt;
  int  words_in;
  bit  holding_off;

  rational_cubic_resampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .out_phase_o   (out_phase_o),
    .last_of_run_o (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        checker_h.take_sample(sample_in_i);
        words_in++;
      end
      if (out_valid_o && !out_stall_i)
        checker_h.check_output(sample_out_o, out_phase_o, last_of_run_o);
    end
  end

  task automatic send_word(sample_t v);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_input(int n);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    sample_in_i <= sample_t'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return sample_t'(32767);
    if (pick < 6) return sample_t'(-32768);
    if (pick < 8) return sample_t'($urandom_range(0, 15) - 8);
    return sample_t'($urandom);
  endfunction

  // receiver: stall patterns in stretches, plus one long hold-off to back up the queue
  initial begin
    int mode;
    int len;
    bit hold_done;
    out_stall_i = 1'b0;
    holding_off = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!hold_done && words_in >= 120) begin
        holding_off = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (90) @(negedge clk_i);
        holding_off = 1'b0;
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 1);
          2:       out_stall_i <= ($urandom_range(0, 6) == 0);
          default: out_stall_i <= cyc_cnt[1];
        endcase
      end
    end
  end

  initial begin
    sample_t directed[$];
    int sent;
    int burst;
    checker_h = new();
    cyc_cnt = 0;
    words_in = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_in_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // extremes, alternating and held extremes to drive saturation, bit patterns, small values
    directed = '{sample_t'(32767), sample_t'(-32768), sample_t'(32767), sample_t'(-32768),
                 sample_t'(-32768), sample_t'(32767), sample_t'(32767), sample_t'(-32768),
                 sample_t'(-32768), sample_t'(32767), sample_t'(0), sample_t'(0),
                 sample_t'(-1), sample_t'(1), sample_t'(16'h5555), sample_t'(16'hAAAA),
                 sample_t'(32767), sample_t'(32767), sample_t'(32767), sample_t'(32767),
                 sample_t'(-32768), sample_t'(-32768), sample_t'(-32768), sample_t'(-32768),
                 sample_t'(0)};
    foreach (directed[i]) send_word(directed[i]);

    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 16);
      for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
        send_word(random_sample());
        sent++;
      end
      if (!holding_off && $urandom_range(0, 3) != 0) idle_input($urandom_range(1, 7));
    end
    idle_input(1);

    while (checker_h.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (checker_h.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
